// ===== hw/rtl/dtwd_pkg.sv =====
`timescale 1ns / 1ps

package dtwd_pkg;

	localparam int MAX_POINTS = 256;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int LEN_W      = $clog2(MAX_POINTS + 1);
	localparam int COORD_W    = 16;
	localparam int DIST_W     = 27;
	localparam int COST_W     = COORD_W + 2;

	localparam logic [DIST_W-1:0] DIST_LIMIT = 27'd99999999;

	localparam logic CMD_QUERY    = 1'b0;
	localparam logic CMD_TEMPLATE = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RUN   = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_FIN   = 4'b1000
	} state_t;

	// column read in flight
	typedef struct packed {
		logic             vld;
		logic [IDX_W-1:0] idx;
		logic             first;
	} rd_ctl_t;

	// column write back
	typedef struct packed {
		logic              vld;
		logic [IDX_W-1:0]  idx;
		logic [DIST_W-1:0] score;
	} col_wr_t;

endpackage

// ===== hw/rtl/dtwd_cell.sv =====
`timescale 1ns / 1ps

module dtwd_cell import dtwd_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rd_ctl_t                   rd_s1,
	input  logic signed [COORD_W-1:0] qx_s1,
	input  logic signed [COORD_W-1:0] qy_s1,
	input  logic signed [COORD_W-1:0] tx,
	input  logic signed [COORD_W-1:0] ty,
	input  logic [DIST_W-1:0]         col_s1,
	output col_wr_t                   wr
);

	logic [COORD_W:0]   dx, dy, adx, ady;
	logic [COST_W-1:0]  cost;
	logic [DIST_W-1:0]  left, diag, m_lr;
	logic [DIST_W-1:0]  prev_left_q;

	logic               vld_s2;
	logic [IDX_W-1:0]   idx_s2;
	logic [COST_W-1:0]  cost_s2;
	logic [DIST_W-1:0]  m_s2;

	logic [DIST_W-1:0]  up_q, up, m_all;
	logic [DIST_W:0]    sum;
	logic [DIST_W-1:0]  score;

	always_comb begin
		dx   = {qx_s1[COORD_W-1], qx_s1} - {tx[COORD_W-1], tx};
		dy   = {qy_s1[COORD_W-1], qy_s1} - {ty[COORD_W-1], ty};
		adx  = dx[COORD_W] ? ((COORD_W+1)'(0) - dx) : dx;
		ady  = dy[COORD_W] ? ((COORD_W+1)'(0) - dy) : dy;
		cost = {1'b0, adx} + {1'b0, ady};
		left = rd_s1.first ? DIST_LIMIT : col_s1;
		if (rd_s1.idx == '0) begin
			diag = rd_s1.first ? '0 : DIST_LIMIT;
		end else begin
			diag = prev_left_q;
		end
		m_lr = (left < diag) ? left : diag;
	end

	always_ff @(posedge clk) begin
		if (rd_s1.vld) begin
			prev_left_q <= left;
			cost_s2     <= cost;
			m_s2        <= m_lr;
			idx_s2      <= rd_s1.idx;
		end
		if (vld_s2) begin
			up_q <= score;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= rd_s1.vld;
		end
	end

	always_comb begin
		up    = (idx_s2 == '0) ? DIST_LIMIT : up_q;
		m_all = (up < m_s2) ? up : m_s2;
		sum   = {1'b0, m_all} + (DIST_W+1)'(cost_s2);
		score = (sum > {1'b0, DIST_LIMIT}) ? DIST_LIMIT : sum[DIST_W-1:0];
	end

	assign wr.vld   = vld_s2;
	assign wr.idx   = idx_s2;
	assign wr.score = score;

endmodule

// ===== hw/rtl/dtw_point_sequence_distance_top.sv =====
// Query point: taken while idle; the next request is accepted right after.
// Template point: new requests stall while the column memory is walked one
// cell per cycle through a two-stage read/compute/write-back loop and drained;
// an empty query skips the walk. A final template point passes a finish state
// before the result shows, and waits there while an older result is stalled.
// Reset clears the sequencer and counters; the memories keep their contents.
`timescale 1ns / 1ps

module dtw_point_sequence_distance_top import dtwd_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_stall,
	input  logic                      cmd,
	input  logic signed [COORD_W-1:0] point_x,
	input  logic signed [COORD_W-1:0] point_y,
	input  logic                      last,
	output logic                      result_valid,
	input  logic                      result_stall,
	output logic [DIST_W-1:0]         distance,
	output logic                      overflow
);

	state_t                    state_q;
	logic [LEN_W-1:0]          qlen_q;
	logic [LEN_W-1:0]          tc_q;
	logic                      closed_q;
	logic                      ovf_q;
	logic                      dropped_q;
	logic                      first_q;
	logic                      fin_q;
	logic [IDX_W-1:0]          rd_idx_q;
	logic signed [COORD_W-1:0] tx_q, ty_q;
	logic [DIST_W-1:0]         last_cell_q;
	logic                      result_valid_q;
	logic [DIST_W-1:0]         distance_q;
	logic                      overflow_q;

	logic [2*COORD_W-1:0]      qmem [MAX_POINTS];
	logic [DIST_W-1:0]         cmem [MAX_POINTS];
	logic [2*COORD_W-1:0]      q_s1;
	logic [DIST_W-1:0]         col_s1;
	rd_ctl_t                   rd_s1;
	col_wr_t                   wr;

	logic                      accept;
	logic                      issue;
	logic                      rd_last;
	logic                      q_wr;
	logic [IDX_W-1:0]          q_addr;
	logic                      res_free;

	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;
	assign issue      = (state_q == ST_RUN);
	assign rd_last    = (LEN_W'(rd_idx_q) + LEN_W'(1) == qlen_q);
	assign q_wr       = accept && (cmd == CMD_QUERY) &&
	                    (closed_q || (qlen_q < LEN_W'(MAX_POINTS)));
	assign q_addr     = closed_q ? '0 : qlen_q[IDX_W-1:0];
	assign res_free   = !result_valid_q || !result_stall;

	// reads run ahead of write-back by two entries, so no same-entry overlap
	always_ff @(posedge clk) begin
		if (q_wr) begin
			qmem[q_addr] <= {point_y, point_x};
		end
		if (issue) begin
			q_s1 <= qmem[rd_idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (wr.vld) begin
			cmem[wr.idx] <= wr.score;
		end
		if (issue) begin
			col_s1 <= cmem[rd_idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= '0;
		end else begin
			rd_s1.vld   <= issue;
			rd_s1.idx   <= rd_idx_q;
			rd_s1.first <= first_q;
		end
	end

	dtwd_cell u_cell (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_s1  (rd_s1),
		.qx_s1  (q_s1[COORD_W-1:0]),
		.qy_s1  (q_s1[2*COORD_W-1:COORD_W]),
		.tx     (tx_q),
		.ty     (ty_q),
		.col_s1 (col_s1),
		.wr     (wr)
	);

	always_ff @(posedge clk) begin
		if (wr.vld && (LEN_W'(wr.idx) + LEN_W'(1) == qlen_q)) begin
			last_cell_q <= wr.score;
		end
		if (accept && (cmd == CMD_TEMPLATE)) begin
			tx_q <= point_x;
			ty_q <= point_y;
		end
		if (state_q == ST_FIN && res_free) begin
			distance_q <= (qlen_q == '0) ? DIST_LIMIT : last_cell_q;
			overflow_q <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			qlen_q         <= '0;
			tc_q           <= '0;
			closed_q       <= 1'b1;
			ovf_q          <= 1'b0;
			dropped_q      <= 1'b0;
			first_q        <= 1'b0;
			fin_q          <= 1'b0;
			rd_idx_q       <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && cmd == CMD_QUERY) begin
						tc_q     <= '0;
						closed_q <= last;
						if (closed_q) begin
							qlen_q    <= LEN_W'(1);
							dropped_q <= 1'b0;
							ovf_q     <= 1'b0;
						end else if (qlen_q < LEN_W'(MAX_POINTS)) begin
							qlen_q <= qlen_q + LEN_W'(1);
							ovf_q  <= dropped_q;
						end else begin
							dropped_q <= 1'b1;
							ovf_q     <= 1'b1;
						end
					end else if (accept) begin
						closed_q <= 1'b1;
						fin_q    <= last;
						if (tc_q < LEN_W'(MAX_POINTS)) begin
							tc_q    <= tc_q + LEN_W'(1);
							first_q <= (tc_q == '0);
							if (qlen_q != '0) begin
								rd_idx_q <= '0;
								state_q  <= ST_RUN;
							end else if (last) begin
								state_q <= ST_FIN;
							end
						end else begin
							ovf_q <= 1'b1;
							if (last) begin
								state_q <= ST_FIN;
							end
						end
					end
				end
				ST_RUN: begin
					rd_idx_q <= rd_idx_q + IDX_W'(1);
					if (rd_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!rd_s1.vld && !wr.vld) begin
						state_q <= fin_q ? ST_FIN : ST_IDLE;
					end
				end
				ST_FIN: begin
					if (res_free) begin
						result_valid_q <= 1'b1;
						tc_q           <= '0;
						ovf_q          <= dropped_q;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result_valid = result_valid_q;
	assign distance     = distance_q;
	assign overflow     = overflow_q;

	a_wr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		wr.vld |-> (state_q == ST_DRAIN || state_q == ST_RUN))
		else $error("column write outside a column pass");

	a_wr_idx: assert property (@(posedge clk) disable iff (!arst_n)
		wr.vld |-> (LEN_W'(wr.idx) < qlen_q))
		else $error("column write beyond query length");

	a_tc_range: assert property (@(posedge clk) disable iff (!arst_n)
		tc_q <= LEN_W'(MAX_POINTS))
		else $error("template count out of range");

	a_fin_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && res_free) |=> (result_valid && tc_q == '0))
		else $error("result not loaded on completion");

endmodule

// ===== test/dtw_point_sequence_distance_top_tb.sv =====
`timescale 1ns / 1ps

module dtw_point_sequence_distance_top_tb;
	import dtwd_pkg::*;

	localparam int unsigned SAT = 32'(DIST_LIMIT);
	localparam int QUIET_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 300;

	typedef struct packed {
		logic [DIST_W-1:0] d_val;
		logic              ovf;
	} dtw_outcome_t;

	logic                      clk;
	logic                      arst_n = 1'b0;
	logic                      item_valid = 1'b0;
	logic                      item_stall;
	logic                      cmd = CMD_QUERY;
	logic signed [COORD_W-1:0] point_x = '0;
	logic signed [COORD_W-1:0] point_y = '0;
	logic                      last = 1'b0;
	logic                      result_valid;
	logic                      result_stall = 1'b0;
	logic [DIST_W-1:0]         distance;
	logic                      overflow;

	// predictor state
	logic signed [COORD_W-1:0] q_x [MAX_POINTS];
	logic signed [COORD_W-1:0] q_y [MAX_POINTS];
	int unsigned               dtw_col [MAX_POINTS];
	int unsigned               q_len = 0;
	int unsigned               t_count = 0;
	bit                        q_closed = 1'b1;
	bit                        ovf_flag = 1'b0;
	bit                        q_dropped = 1'b0;

	dtw_outcome_t expected_distances[$];

	int idle_pct = 0;
	int stall_pct = 0;
	int points_sent = 0;
	int query_points = 0;
	int template_points = 0;
	int checked_results = 0;
	int mismatches = 0;
	int quiet_cycles = 0;

	dtw_point_sequence_distance_top i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.cmd         (cmd),
		.point_x     (point_x),
		.point_y     (point_y),
		.last        (last),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.distance    (distance),
		.overflow    (overflow)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned abs_gap(input int a, input int b);
		return (a >= b) ? int'(a - b) : int'(b - a);
	endfunction

	task automatic advance_column(input int tx, input int ty);
		int unsigned diag, up, left, acc;
		int i;
		diag = (t_count == 0) ? 0 : SAT;
		up = SAT;
		for (i = 0; i < int'(q_len); i++) begin
			left = (t_count == 0) ? SAT : dtw_col[i];
			acc = (up < left) ? up : left;
			if (diag < acc)
				acc = diag;
			acc = acc + abs_gap(int'(q_x[i]), tx) + abs_gap(int'(q_y[i]), ty);
			if (acc > SAT)
				acc = SAT;
			dtw_col[i] = acc;
			diag = left;
			up = acc;
		end
	endtask

	task automatic predict_dtw(input logic c, input int px, input int py, input logic fin);
		dtw_outcome_t res;
		if (c == CMD_QUERY) begin
			query_points++;
			if (q_closed) begin
				q_len = 0;
				q_closed = 1'b0;
				q_dropped = 1'b0;
			end
			t_count = 0;
			if (q_len < MAX_POINTS) begin
				q_x[q_len] = COORD_W'(px);
				q_y[q_len] = COORD_W'(py);
				q_len++;
			end else begin
				q_dropped = 1'b1;
			end
			ovf_flag = q_dropped;
			if (fin)
				q_closed = 1'b1;
		end else begin
			template_points++;
			q_closed = 1'b1;
			if (t_count < MAX_POINTS) begin
				advance_column(px, py);
				t_count++;
			end else begin
				ovf_flag = 1'b1;
			end
			if (fin) begin
				res.d_val = (q_len > 0) ? DIST_W'(dtw_col[q_len - 1]) : DIST_LIMIT;
				res.ovf = ovf_flag;
				expected_distances.insert(expected_distances.size(), res);
				t_count = 0;
				ovf_flag = q_dropped;
			end
		end
	endtask

	task automatic report_mismatch(input string msg);
		$display("%0t: mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	always @(posedge clk) begin
		dtw_outcome_t want;
		if (arst_n && item_valid && !item_stall)
			predict_dtw(cmd, int'(point_x), int'(point_y), last);
		if (arst_n && result_valid && !result_stall) begin
			checked_results++;
			if (expected_distances.size() == 0) begin
				report_mismatch($sformatf("unexpected result, distance %0d overflow %0b",
					distance, overflow));
			end else begin
				want = expected_distances.pop_front();
				if (distance !== want.d_val)
					report_mismatch($sformatf("distance %0d, expected %0d",
						distance, want.d_val));
				if (overflow !== want.ovf)
					report_mismatch($sformatf("overflow %0b, expected %0b",
						overflow, want.ovf));
			end
		end
	end

	always @(posedge clk) begin
		result_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no request or result moved for %0d cycles",
				$realtime, QUIET_LIMIT);
			$display("FAIL");
			$finish;
		end
	end

	task automatic send_point(input logic c, input logic signed [COORD_W-1:0] x,
		input logic signed [COORD_W-1:0] y, input logic fin);
		if ($urandom_range(0, 99) < idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < idle_pct)
				@(posedge clk);
		end
		item_valid <= 1'b1;
		cmd <= c;
		point_x <= x;
		point_y <= y;
		last <= fin;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		points_sent++;
	endtask

	function automatic logic signed [COORD_W-1:0] rand_coord();
		case ($urandom_range(0, 9))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return '0;
			default: return COORD_W'($urandom);
		endcase
	endfunction

	function automatic int rand_query_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 6);
		else if (r < 95)
			return $urandom_range(7, 40);
		return $urandom_range(41, MAX_POINTS);
	endfunction

	function automatic int rand_template_len();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 6);
		return $urandom_range(7, 30);
	endfunction

	// closed = 0 leaves the sequence without its final point
	task automatic send_sequence(input logic c, input int len, input bit closed);
		int k;
		for (k = 0; k < len; k++)
			send_point(c, rand_coord(), rand_coord(), closed && (k == len - 1));
	endtask

	task automatic test_corner_points();
		// empty query right after reset
		send_point(CMD_TEMPLATE, 16'sh0000, 16'sh0000, 1'b1);
		send_point(CMD_TEMPLATE, 16'sh7fff, 16'sh8000, 1'b0);
		send_point(CMD_TEMPLATE, 16'shffff, 16'sh0005, 1'b1);
		// largest local cost
		send_point(CMD_QUERY, 16'sh8000, 16'sh8000, 1'b1);
		send_point(CMD_TEMPLATE, 16'sh7fff, 16'sh7fff, 1'b1);
		send_point(CMD_QUERY, 16'sh7fff, 16'sh8000, 1'b0);
		send_point(CMD_QUERY, 16'sh0000, 16'sh0000, 1'b0);
		send_point(CMD_QUERY, 16'sh8000, 16'sh7fff, 1'b1);
		send_point(CMD_TEMPLATE, 16'sh8000, 16'sh7fff, 1'b0);
		send_point(CMD_TEMPLATE, 16'sh7fff, 16'sh8000, 1'b1);
		// query reused by a second template
		send_point(CMD_TEMPLATE, 16'sh0000, 16'sh0000, 1'b1);
		// template cut short by a new query
		send_point(CMD_TEMPLATE, 16'sh0001, 16'sh0001, 1'b0);
		send_point(CMD_TEMPLATE, 16'sh0002, 16'sh0002, 1'b0);
		send_point(CMD_QUERY, 16'sh0005, -16'sh0005, 1'b1);
		send_point(CMD_TEMPLATE, 16'sh0005, -16'sh0005, 1'b1);
		// template before the query is closed
		send_point(CMD_QUERY, 16'sh000a, 16'sh000a, 1'b0);
		send_point(CMD_QUERY, 16'sh0014, 16'sh0014, 1'b0);
		send_point(CMD_TEMPLATE, 16'sh000f, 16'sh000f, 1'b1);
		send_point(CMD_QUERY, 16'sh0007, 16'sh0007, 1'b1);
		send_point(CMD_TEMPLATE, 16'sh0007, 16'sh0008, 1'b1);
	endtask

	task automatic test_query_capacity();
		send_sequence(CMD_QUERY, MAX_POINTS, 1'b1);
		send_sequence(CMD_TEMPLATE, 2, 1'b1);
		// dropped points, the final one included; flag sticks across templates
		send_sequence(CMD_QUERY, MAX_POINTS + $urandom_range(1, 4), 1'b1);
		send_sequence(CMD_TEMPLATE, 3, 1'b1);
		send_sequence(CMD_TEMPLATE, 1, 1'b1);
		send_sequence(CMD_QUERY, 2, 1'b1);
		send_sequence(CMD_TEMPLATE, 2, 1'b1);
	endtask

	task automatic test_template_capacity();
		send_sequence(CMD_QUERY, 3, 1'b1);
		send_sequence(CMD_TEMPLATE, MAX_POINTS, 1'b1);
		send_sequence(CMD_TEMPLATE, MAX_POINTS + $urandom_range(1, 5), 1'b1);
		send_sequence(CMD_TEMPLATE, 2, 1'b1);
	endtask

	task automatic test_random_mix(input int count);
		int stop_at;
		int r;
		stop_at = points_sent + count;
		while (points_sent < stop_at) begin
			r = $urandom_range(0, 99);
			if (r < 80) begin
				send_sequence(CMD_QUERY, rand_query_len(), 1'b1);
				repeat ($urandom_range(1, 3))
					send_sequence(CMD_TEMPLATE, rand_template_len(), 1'b1);
			end else if (r < 88) begin
				send_sequence(CMD_TEMPLATE, rand_template_len(), 1'b1);
			end else if (r < 94) begin
				send_sequence(CMD_QUERY, rand_query_len(), 1'b0);
				send_sequence(CMD_TEMPLATE, rand_template_len(), 1'b1);
			end else begin
				send_sequence(CMD_TEMPLATE, rand_template_len(), 1'b0);
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_points();

		idle_pct = 29;
		stall_pct = 29;
		test_query_capacity();
		test_template_capacity();

		idle_pct = 0;
		stall_pct = 0;
		test_random_mix(150);
		idle_pct = 47;
		test_random_mix(150);
		idle_pct = 0;
		stall_pct = 47;
		test_random_mix(150);
		idle_pct = 29;
		stall_pct = 29;
		test_random_mix(150);

		item_valid <= 1'b0;
		while (expected_distances.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d points (%0d query, %0d template)",
			points_sent, query_points, template_points);
		$display("Covered empty query, full and overflowing sequences, interrupted sequences, "
			, "four idle mixes; %0d distances checked, %0d mismatches",
			checked_results, mismatches);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/dtwd_pkg.sv
hw/rtl/dtwd_cell.sv
hw/rtl/dtw_point_sequence_distance_top.sv
test/dtw_point_sequence_distance_top_tb.sv
